/* rtl/core/iirdf2t_pkg.sv */
// Shared types and constants for the multichannel DF2T IIR filter.
`default_nettype none

package iirdf2t_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int STATE_W    = 40;
    localparam int PROD_W     = 34;
    localparam int WORD_IDX_W = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 54;

    // Delay words per channel in the storage layout.
    localparam int WORDS_PER_CH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FF_LOW_THREE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_HIGH_TWO  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_LOW_THREE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_FOURTH    = 4'd3;

    // Reset value of the packed feedforward register: b0 = 1.0.
    localparam logic [CFG_DATA_W-1:0] FF_LOW_RESET = 54'd16384;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                  load_in;
        logic                  load_y;
        logic                  mul_en;
        logic [WORD_IDX_W-1:0] mul_idx;
        logic                  rd_en;
        logic [WORD_IDX_W-1:0] rd_idx;
        logic                  comb_en;
        logic [WORD_IDX_W-1:0] comb_idx;
        logic                  comb_chain;
        logic                  load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/iir_filter_df2t_4th_order_top.sv */
// Top level of the multichannel fourth-order DF2T IIR filter.
//
// Usage:
//   Input beats (s_valid/s_ready) carry one Q0.15 sample, its channel and an
//   end-of-block flag. Result beats (m_valid/m_ready) carry the rounded and
//   saturated filtered sample with the channel and flag copied through.
//   Coefficients are written by the user through the cfg_valid/cfg_ready port,
//   index 0 to 3, while the filter is idle (not enforced by the block); cfg_ready is always high.
// Timing:
//   Delay word 0 is fetched and b0*x is captured at the accepting edge. The
//   YCALC state then forms y, and in the UPDATE state the two shared multipliers
//   and the single storage read port step through the delay words. The next
//   sample is accepted in the cycle after the result is loaded, so a new sample
//   is not taken before the last one is through.
// Reset:
//   aresetn is synchronous and active low. It restores b0 = 1.0 with all other
//   coefficients zero and clears every delay word through per-entry valid bits.
// Back-pressure:
//   A result waits in the output register while m_ready is low; the next sample
//   is accepted and processed meanwhile and stalls only at the final load.
`default_nettype none

module iir_filter_df2t_4th_order_top #(
    parameter int CHANNELS = 2,
    parameter int ORDER    = 4
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      s_valid,
    output logic                                           s_ready,
    input  wire logic                                      s_channel,
    input  wire logic signed [iirdf2t_pkg::SAMPLE_W-1:0]   s_sample,
    input  wire logic                                      s_end_of_block,
    output logic                                           m_valid,
    input  wire logic                                      m_ready,
    output logic                                           m_out_channel,
    output logic signed      [iirdf2t_pkg::SAMPLE_W-1:0]   m_filtered,
    output logic                                           m_out_end_of_block,
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire logic        [iirdf2t_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [iirdf2t_pkg::CFG_DATA_W-1:0] cfg_data
);

    iirdf2t_pkg::cmd_t    cmd;
    iirdf2t_pkg::status_t status;

    // Configuration writes complete in the cycle they are presented.
    assign cfg_ready = 1'b1;

    iirdf2t_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    iirdf2t_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_channel          (s_channel),
        .s_sample           (s_sample),
        .s_end_of_block     (s_end_of_block),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_channel      (m_out_channel),
        .m_filtered         (m_filtered),
        .m_out_end_of_block (m_out_end_of_block),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // A result is never loaded over a beat that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("result register overwritten while a beat was pending");

    // A loaded result is presented in the next cycle.
    a_load_presents: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("loaded result not presented");

    // Only one sample is in flight: no new beat right after one is accepted.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second sample accepted while one is in flight");

    // Delay words are never written and fetched at the same storage slot in one cycle.
    a_rw_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.comb_en && cmd.rd_en) |-> (cmd.comb_idx != cmd.rd_idx))
        else $error("delay word read and written in the same cycle");

endmodule

`default_nettype wire

/* rtl/core/iirdf2t_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module iirdf2t_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/iirdf2t_ctrl.sv */
// Controller that sequences one sample through the filter datapath.
`default_nettype none

module iirdf2t_ctrl #(
    parameter int ORDER = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output iirdf2t_pkg::cmd_t         cmd,
    input  wire iirdf2t_pkg::status_t status
);

    localparam int STEP_W = $clog2(ORDER + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YCALC,
        ST_UPDATE,
        ST_PUSH
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [STEP_W:0]     step_inc;
    logic [STEP_W-1:0]   step_dec;

    assign step_inc = {1'b0, step_reg} + 1'b1;
    assign step_dec = step_reg - 1'b1;

    // Next state and per-cycle commands. In the update phase, step k multiplies the
    // coefficients of word k and fetches word k+1 while word k-1 is combined and written.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_idx  = '0;
                    state_next  = ST_YCALC;
                end
            end
            ST_YCALC: begin
                cmd.load_y = 1'b1;
                step_next  = '0;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (step_reg < STEP_W'(ORDER)) begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_idx = iirdf2t_pkg::WORD_IDX_W'(step_reg);
                end
                if (step_inc < (STEP_W + 1)'(ORDER)) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_idx = iirdf2t_pkg::WORD_IDX_W'(step_inc);
                end
                if (step_reg != '0) begin
                    cmd.comb_en    = 1'b1;
                    cmd.comb_idx   = iirdf2t_pkg::WORD_IDX_W'(step_dec);
                    cmd.comb_chain = (step_reg < STEP_W'(ORDER));
                end
                if (step_reg == STEP_W'(ORDER)) begin
                    if (status.out_free) begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end else begin
                    step_next = STEP_W'(step_inc);
                end
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/iirdf2t_dp.sv */
// Datapath: coefficient registers, multipliers, delay-word storage and result register.
`default_nettype none

module iirdf2t_dp #(
    parameter int CHANNELS = 2
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire iirdf2t_pkg::cmd_t                       cmd,
    output iirdf2t_pkg::status_t                         status,
    input  wire logic                                    s_channel,
    input  wire logic signed [iirdf2t_pkg::SAMPLE_W-1:0] s_sample,
    input  wire logic                                    s_end_of_block,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic                                         m_out_channel,
    output logic signed      [iirdf2t_pkg::SAMPLE_W-1:0] m_filtered,
    output logic                                         m_out_end_of_block,
    input  wire logic                                    cfg_valid,
    input  wire logic        [iirdf2t_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [iirdf2t_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = CHANNELS * iirdf2t_pkg::WORDS_PER_CH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SW     = iirdf2t_pkg::STATE_W;
    localparam int CW     = iirdf2t_pkg::COEF_W;
    localparam int PW     = iirdf2t_pkg::PROD_W;
    localparam int XW     = iirdf2t_pkg::SAMPLE_W;

    // Configuration registers.
    logic [53:0] ff_low_reg;
    logic [35:0] ff_high_reg;
    logic [53:0] fb_low_reg;
    logic [17:0] fb_fourth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff_low_reg    <= iirdf2t_pkg::FF_LOW_RESET;
            ff_high_reg   <= '0;
            fb_low_reg    <= '0;
            fb_fourth_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                iirdf2t_pkg::CFG_FF_LOW_THREE: ff_low_reg    <= cfg_data[53:0];
                iirdf2t_pkg::CFG_FF_HIGH_TWO:  ff_high_reg   <= cfg_data[35:0];
                iirdf2t_pkg::CFG_FB_LOW_THREE: fb_low_reg    <= cfg_data[53:0];
                iirdf2t_pkg::CFG_FB_FOURTH:    fb_fourth_reg <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // Storage base address of the incoming channel; channels past the top share the last one.
    logic [ADDR_W-1:0] ch_ext, ch_sel, base_in;
    assign ch_ext  = ADDR_W'(s_channel);
    assign ch_sel  = (ch_ext < ADDR_W'(CHANNELS)) ? ch_ext : ADDR_W'(CHANNELS - 1);
    assign base_in = ch_sel << 2;

    // Sample context registers.
    logic signed [XW-1:0] x_reg;
    logic                 ch_reg, eob_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic signed [PW-1:0] p0_reg, pb_reg, pa_reg;
    logic signed [XW-1:0] y_reg, y_next;

    logic signed [CW-1:0] b0_w, b_sel, a_sel;
    logic signed [PW-1:0] p0_w, pb_w, pa_w;

    assign b0_w = ff_low_reg[17:0];
    assign p0_w = b0_w * s_sample;

    // Coefficient pair for the word being multiplied.
    always_comb begin
        case (cmd.mul_idx)
            2'd0: begin
                b_sel = ff_low_reg[35:18];
                a_sel = fb_low_reg[17:0];
            end
            2'd1: begin
                b_sel = ff_low_reg[53:36];
                a_sel = fb_low_reg[35:18];
            end
            2'd2: begin
                b_sel = ff_high_reg[17:0];
                a_sel = fb_low_reg[53:36];
            end
            default: begin
                b_sel = ff_high_reg[35:18];
                a_sel = fb_fourth_reg;
            end
        endcase
    end

    assign pb_w = b_sel * x_reg;
    assign pa_w = a_sel * y_reg;

    // Delay-word storage with per-entry valid bits; unwritten words read as zero.
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [SW-1:0]     rdata, wdata;
    logic signed [SW-1:0] old_w;

    assign raddr = (cmd.load_in ? base_in : base_reg) + ADDR_W'(cmd.rd_idx);
    assign waddr = base_reg + ADDR_W'(cmd.comb_idx);
    assign old_w = rd_valid_reg ? $signed(rdata) : '0;

    iirdf2t_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.comb_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cmd.comb_en) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.rd_en) begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    // Output sample: round b0*x + s0 to Q0.15 and saturate.
    logic signed [55:0] acc_w, yfull_w;
    always_comb begin
        acc_w   = 56'(p0_reg) + (56'(old_w) <<< 15) + 56'sd8192;
        yfull_w = acc_w >>> 14;
        if (yfull_w > 56'sd32767) begin
            y_next = 16'sh7FFF;
        end else if (yfull_w < -56'sd32768) begin
            y_next = 16'sh8000;
        end else begin
            y_next = yfull_w[XW-1:0];
        end
    end

    // Delay-word update: round b*x - a*y to 14 fraction bits, add the next word, saturate.
    logic signed [34:0] t_w;
    logic signed [35:0] tr_w;
    logic signed [20:0] v_w;
    logic signed [40:0] sum_w;
    always_comb begin
        t_w   = 35'(pb_reg) - 35'(pa_reg);
        tr_w  = 36'(t_w) + 36'sd16384;
        v_w   = 21'(tr_w >>> 15);
        sum_w = 41'(v_w) + (cmd.comb_chain ? 41'(old_w) : 41'sd0);
        if (sum_w[40] != sum_w[39]) begin
            wdata = sum_w[40] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
        end else begin
            wdata = sum_w[SW-1:0];
        end
    end

    // Payload registers of the datapath.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg    <= s_sample;
            ch_reg   <= s_channel;
            eob_reg  <= s_end_of_block;
            base_reg <= base_in;
            p0_reg   <= p0_w;
        end
        if (cmd.load_y) begin
            y_reg <= y_next;
        end
        if (cmd.mul_en) begin
            pb_reg <= pb_w;
            pa_reg <= pa_w;
        end
    end

    // Result register; it holds a beat until the receiver takes it.
    logic m_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_out_channel      <= ch_reg;
            m_filtered         <= y_reg;
            m_out_end_of_block <= eob_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the two-channel fourth-order DF2T IIR filter top level.
`default_nettype none

module tb;

    localparam int SAMPLE_W      = iirdf2t_pkg::SAMPLE_W;
    localparam int COEF_W        = iirdf2t_pkg::COEF_W;
    localparam int CFG_IDX_W     = iirdf2t_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = iirdf2t_pkg::CFG_DATA_W;
    localparam int CH_COUNT      = 2;
    localparam int FILTER_ORDER  = 4;
    localparam int SETTLE_CYCLES = FILTER_ORDER + 6;
    localparam int LIMIT_CYCLES  = 400000;
    localparam longint STATE_MAX = 64'sd549755813887;
    localparam longint STATE_MIN = -64'sd549755813888;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = {CFG_IDX_W{1'b1}};

    // One filtered sample as the result channel should present it.
    typedef struct {
        logic                       chan;
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       eob;
    } filt_out_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_channel;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic                       s_end_of_block;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_out_channel;
    logic signed [SAMPLE_W-1:0] m_filtered;
    logic                       m_out_end_of_block;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    // Predictor copy of the coefficient registers and the delay words.
    logic [53:0]        ff_low_coefs;
    logic [35:0]        ff_high_coefs;
    logic [53:0]        fb_low_coefs;
    logic [COEF_W-1:0]  fb_fourth_coef;
    longint             delay_state [CH_COUNT][4];

    filt_out_t expected_outputs [$];
    int        mismatch_count;
    int        cycle_count;
    int        hold_request;
    bit        send_idle;
    bit        recv_idle;

    iir_filter_df2t_4th_order_top #(
        .CHANNELS (CH_COUNT),
        .ORDER    (FILTER_ORDER)
    ) i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_channel          (s_channel),
        .s_sample           (s_sample),
        .s_end_of_block     (s_end_of_block),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_channel      (m_out_channel),
        .m_filtered         (m_filtered),
        .m_out_end_of_block (m_out_end_of_block),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run-length guard.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // Sign-extends one packed Q4.14 coefficient.
    function automatic longint coef_of(logic [COEF_W-1:0] raw);
        logic signed [COEF_W-1:0] sraw;
        sraw = raw;
        return longint'(sraw);
    endfunction

    // Filters one sample in the predictor and advances its delay words.
    function automatic filt_out_t filter_sample(logic chan, logic signed [SAMPLE_W-1:0] x_in,
                                                logic eob);
        longint    b [5];
        longint    a [5];
        longint    old [4];
        longint    x, acc, y, t, v;
        int        c;
        filt_out_t res;
        c = (int'(chan) < CH_COUNT) ? int'(chan) : CH_COUNT - 1;
        x = longint'(x_in);
        b[0] = coef_of(ff_low_coefs[17:0]);
        b[1] = coef_of(ff_low_coefs[35:18]);
        b[2] = coef_of(ff_low_coefs[53:36]);
        b[3] = coef_of(ff_high_coefs[17:0]);
        b[4] = coef_of(ff_high_coefs[35:18]);
        a[0] = 0;
        a[1] = coef_of(fb_low_coefs[17:0]);
        a[2] = coef_of(fb_low_coefs[35:18]);
        a[3] = coef_of(fb_low_coefs[53:36]);
        a[4] = coef_of(fb_fourth_coef);
        for (int i = 0; i < 4; i++) old[i] = delay_state[c][i];

        // Output: b0*x plus word 0 at 29 fractional bits, rounded to Q0.15.
        acc = b[0] * x + old[0] * 32768;
        y = (acc + 8192) >>> 14;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;

        // Transposed update; the last used word takes no chained term.
        for (int i = 0; i < FILTER_ORDER && i < 4; i++) begin
            t = b[i+1] * x - a[i+1] * y;
            v = (t + 16384) >>> 15;
            if (i + 1 < FILTER_ORDER && i + 1 < 4) v += old[i+1];
            if (v > STATE_MAX) v = STATE_MAX;
            if (v < STATE_MIN) v = STATE_MIN;
            delay_state[c][i] = v;
        end

        res.chan     = chan;
        res.filtered = y[SAMPLE_W-1:0];
        res.eob      = eob;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("tb: mismatch: %s", msg);
    endtask

    // Compare every result beat with the oldest expected output.
    always @(posedge aclk) begin
        filt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected result ch=%0d y=%0d",
                                          m_out_channel, m_filtered));
            end else begin
                want = expected_outputs.pop_front();
                if (m_out_channel !== want.chan)
                    report_mismatch($sformatf("out_channel got %0d want %0d",
                                              m_out_channel, want.chan));
                if (m_filtered !== want.filtered)
                    report_mismatch($sformatf("filtered got %0d want %0d",
                                              m_filtered, want.filtered));
                if (m_out_end_of_block !== want.eob)
                    report_mismatch($sformatf("out_end_of_block got %0d want %0d",
                                              m_out_end_of_block, want.eob));
            end
        end
    end

    // Result-side ready: random stalls per beat, or one long hold on request.
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = recv_idle ? $urandom_range(0, 6) : 0;
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end
            repeat (stall) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    // Offers one sample beat and records its prediction once accepted.
    // Valid is only lowered for a gap, so back-to-back beats keep it high.
    task automatic push_sample(logic chan, logic signed [SAMPLE_W-1:0] x, logic eob);
        int gap;
        gap = send_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_channel      <= chan;
        s_sample       <= x;
        s_end_of_block <= eob;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_outputs.push_back(filter_sample(chan, x, eob));
    endtask

    // Stops offering samples and waits for the filter to go idle.
    task automatic drain_filter();
        s_valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain_filter();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            iirdf2t_pkg::CFG_FF_LOW_THREE: ff_low_coefs   = data[53:0];
            iirdf2t_pkg::CFG_FF_HIGH_TWO:  ff_high_coefs  = data[35:0];
            iirdf2t_pkg::CFG_FB_LOW_THREE: fb_low_coefs   = data[53:0];
            iirdf2t_pkg::CFG_FB_FOURTH:    fb_fourth_coef = data[COEF_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Writes a full coefficient set, all four registers.
    task automatic set_coefs(int b0, int b1, int b2, int b3, int b4,
                             int a1, int a2, int a3, int a4);
        write_coef(iirdf2t_pkg::CFG_FF_LOW_THREE,
                   CFG_DATA_W'({18'(b2), 18'(b1), 18'(b0)}));
        write_coef(iirdf2t_pkg::CFG_FF_HIGH_TWO,
                   CFG_DATA_W'({18'(b4), 18'(b3)}));
        write_coef(iirdf2t_pkg::CFG_FB_LOW_THREE,
                   CFG_DATA_W'({18'(a3), 18'(a2), 18'(a1)}));
        write_coef(iirdf2t_pkg::CFG_FB_FOURTH, CFG_DATA_W'(18'(a4)));
    endtask

    function automatic int rand_coef(int span);
        return int'($urandom_range(0, 2 * span - 1)) - span;
    endfunction

    // Mostly full-range samples, some extremes and some small values.
    task automatic push_random_sample();
        logic signed [SAMPLE_W-1:0] x;
        int                         mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0: begin
                case ($urandom_range(0, 3))
                    0: x = 16'sh7FFF;
                    1: x = 16'sh8000;
                    2: x = 16'sh0000;
                    default: x = 16'shFFFF;
                endcase
            end
            1, 2: x = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            default: x = SAMPLE_W'($urandom);
        endcase
        push_sample(1'($urandom), x, ($urandom_range(0, 7) == 0));
    endtask

    // Reset coefficients give a straight passthrough at the sample extremes.
    task automatic test_reset_passthrough();
        push_sample(1'b0, 16'sh7FFF, 1'b0);
        push_sample(1'b1, 16'sh8000, 1'b1);
        push_sample(1'b0, 16'sh0000, 1'b0);
        push_sample(1'b1, 16'shFFFF, 1'b0);
        push_sample(1'b0, 16'sh0001, 1'b1);
        push_sample(1'b1, 16'sh3039, 1'b0);
    endtask

    // Output saturation at both gain extremes and rounding of half steps.
    task automatic test_gain_and_rounding();
        set_coefs(131071, 0, 0, 0, 0, 0, 0, 0, 0);
        push_sample(1'b0, 16'sh7FFF, 1'b0);
        push_sample(1'b1, 16'sh8000, 1'b0);
        set_coefs(-131072, 0, 0, 0, 0, 0, 0, 0, 0);
        push_sample(1'b0, 16'sh8000, 1'b1);
        push_sample(1'b1, 16'sh7FFF, 1'b0);
        set_coefs(8192, 0, 0, 0, 0, 0, 0, 0, 0);
        push_sample(1'b0, 16'sh0001, 1'b0);
        push_sample(1'b0, 16'shFFFF, 1'b0);
        push_sample(1'b1, 16'sh0003, 1'b0);
        push_sample(1'b1, 16'shFFFD, 1'b1);
    endtask

    // Impulse through a full fourth-order section, then a second-order one,
    // then register writes with unused upper bits and unused indexes.
    task automatic test_filter_orders();
        set_coefs(4096, 8192, 4096, -2048, 1024, -8000, 6000, -2000, 500);
        push_sample(1'b0, 16'sh4000, 1'b0);
        push_sample(1'b1, 16'shC000, 1'b0);
        push_sample(1'b0, 16'sh0000, 1'b0);
        push_sample(1'b0, 16'sh0000, 1'b0);
        push_sample(1'b1, 16'sh0000, 1'b0);
        push_sample(1'b0, 16'sh0000, 1'b1);
        set_coefs(4096, 8192, 4096, 0, 0, -12000, 5000, 0, 0);
        push_sample(1'b0, 16'sh7000, 1'b0);
        push_sample(1'b0, 16'sh0000, 1'b0);
        push_sample(1'b1, 16'sh0000, 1'b1);
        write_coef(iirdf2t_pkg::CFG_FF_HIGH_TWO, CFG_DATA_W'({$urandom, $urandom}));
        write_coef(iirdf2t_pkg::CFG_FB_FOURTH, CFG_DATA_W'({$urandom, $urandom}));
        write_coef(CFG_IDX_W'($urandom_range(iirdf2t_pkg::CFG_FB_FOURTH + 1, CFG_IDX_LAST)),
                   CFG_DATA_W'({$urandom, $urandom}));
        write_coef(CFG_IDX_LAST, CFG_DATA_W'({$urandom, $urandom}));
        push_sample(1'b0, SAMPLE_W'($urandom), 1'b0);
        push_sample(1'b1, SAMPLE_W'($urandom), 1'b1);
    endtask

    // Random samples under a sequence of coefficient sets, extremes included.
    task automatic test_random_settings();
        int span_b;
        int span_a;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_coefs(16384, 0, 0, 0, 0, 0, 0, 0, 0);
                1: set_coefs(131071, 131071, 131071, 131071, 131071,
                             131071, 131071, 131071, 131071);
                2: set_coefs(-131072, -131072, -131072, -131072, -131072,
                             -131072, -131072, -131072, -131072);
                3: set_coefs(0, 0, 0, 0, 0, 0, 0, 0, 0);
                default: begin
                    span_b = (phase < 6) ? 4096 : 131072;
                    span_a = (phase < 6) ? 8192 : 131072;
                    set_coefs(rand_coef(span_b), rand_coef(span_b), rand_coef(span_b),
                              rand_coef(span_b), rand_coef(span_b), rand_coef(span_a),
                              rand_coef(span_a), rand_coef(span_a), rand_coef(span_a));
                end
            endcase
            send_idle = ($urandom_range(0, 2) != 0);
            recv_idle = ($urandom_range(0, 2) != 0);
            repeat (225) push_random_sample();
        end
    endtask

    // Long receiver hold while the sender keeps offering back-to-back beats.
    task automatic test_output_backpressure();
        set_coefs(rand_coef(4096), rand_coef(4096), rand_coef(4096), rand_coef(4096),
                  rand_coef(4096), rand_coef(8192), rand_coef(8192), rand_coef(8192),
                  rand_coef(8192));
        send_idle    = 1'b0;
        recv_idle    = 1'b1;
        hold_request = 300;
        repeat (60) push_random_sample();
    endtask

    // Sender stops until every result is out, then resumes on the same state.
    task automatic test_sender_pause();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (30) push_random_sample();
        drain_filter();
        repeat (30) push_random_sample();
    endtask

    initial begin
        mismatch_count = 0;
        hold_request   = 0;
        send_idle      = 1'b1;
        recv_idle      = 1'b1;
        ff_low_coefs   = 54'd16384;
        ff_high_coefs  = '0;
        fb_low_coefs   = '0;
        fb_fourth_coef = '0;
        for (int c = 0; c < CH_COUNT; c++)
            for (int i = 0; i < 4; i++) delay_state[c][i] = 0;

        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_channel      <= 1'b0;
        s_sample       <= '0;
        s_end_of_block <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= iirdf2t_pkg::CFG_FF_LOW_THREE;
        cfg_data       <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        test_reset_passthrough();
        test_gain_and_rounding();
        test_filter_orders();
        test_random_settings();
        test_output_backpressure();
        test_sender_pause();

        drain_filter();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_outputs.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* iir_filter_df2t_4th_order_top.f */
rtl/core/iirdf2t_pkg.sv
rtl/core/iirdf2t_ram.sv
rtl/core/iirdf2t_ctrl.sv
rtl/core/iirdf2t_dp.sv
rtl/core/iir_filter_df2t_4th_order_top.sv
bench/tb.sv
